### rtl/core/jst_pkg.sv
// Package for the JSON stream tokenizer: event and error codes, container
// states, leaf modes, the input word type and the result word type. No dependencies.
`default_nettype none
package jst_pkg;

  typedef enum logic [3:0] {
    EV_OBJ_OPEN  = 4'd0,
    EV_OBJ_CLOSE = 4'd1,
    EV_NAME_CHAR = 4'd2,
    EV_NAME_END  = 4'd3,
    EV_STR_CHAR  = 4'd4,
    EV_STR_END   = 4'd5,
    EV_NUM_CHAR  = 4'd6,
    EV_NUM_END   = 4'd7,
    EV_TRUE      = 4'd8,
    EV_FALSE     = 4'd9,
    EV_NULL      = 4'd10,
    EV_ARR_OPEN  = 4'd11,
    EV_ARR_CLOSE = 4'd12,
    EV_ERROR     = 4'd13
  } event_t;

  typedef enum logic [2:0] {
    ER_NONE      = 3'd0,
    ER_UNEXP     = 3'd1,
    ER_END       = 3'd2,
    ER_NO_DIGITS = 3'd3,
    ER_POINT     = 3'd4,
    ER_EMPTY     = 3'd5,
    ER_DEEP      = 3'd6
  } err_t;

  // Container state kept in one stack cell.
  typedef enum logic [2:0] {
    S_OBJ_BEGIN = 3'd0,
    S_OBJ_COLON = 3'd1,
    S_OBJ_VALUE = 3'd2,
    S_OBJ_END   = 3'd3,
    S_ARR_BEGIN = 3'd4,
    S_ARR_VALUE = 3'd5,
    S_ARR_END   = 3'd6
  } cstate_t;

  typedef enum logic [2:0] {
    L_NONE  = 3'd0,
    L_NAME  = 3'd1,
    L_STR   = 3'd2,
    L_NUM   = 3'd3,
    L_TRUE  = 3'd4,
    L_FALSE = 3'd5,
    L_NULL  = 3'd6
  } leaf_t;

  // Stack operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_WRTOP = 3'd3,
    OP_CLEAR = 3'd4
  } sop_t;

  // On a push, data is the new top and old_top is what the old top becomes.
  typedef struct packed {
    sop_t    op;
    cstate_t data;
    cstate_t old_top;
  } stk_ctl_t;

  // One input word: a text byte or an end-of-input mark.
  typedef struct packed {
    logic       end_of_input;
    logic [7:0] in_char;
  } tok_in_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] char_out;
    logic [5:0] nest_level;
    logic [2:0] error_code;
    logic       last_event;
  } res_t;

  // Expected byte of a literal at a given index.
  function automatic logic [7:0] lit_char(input leaf_t m, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (m)
      L_TRUE: begin
        case (i)
          3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
        endcase
      end
      L_FALSE: begin
        case (i)
          3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      L_NULL: begin
        case (i)
          3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/jst_stream_if.sv
// Valid/ready stream interface with a parameterized payload type.
// Used by the tokenizer core for its input and result channels.
`default_nettype none
interface jst_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/jst_cell.sv
// One cell of the container stack: holds one entry and shifts it to its
// neighbors on push and pop. Depends on jst_pkg.
`default_nettype none
module jst_cell (
  input  wire logic             clk,
  input  wire jst_pkg::stk_ctl_t ctl,
  input  wire jst_pkg::cstate_t  from_above,
  input  wire jst_pkg::cstate_t  from_below,
  input  wire logic             is_top,
  output jst_pkg::cstate_t       entry
);
  import jst_pkg::*;

  cstate_t entry_r, entry_nxt;

  // Push shifts down toward deeper cells, pop shifts back up.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_PUSH:  entry_nxt = from_above;
      OP_POP:   entry_nxt = from_below;
      OP_WRTOP: if (is_top) begin
        entry_nxt = ctl.data;
      end
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
endmodule
`default_nettype wire

### rtl/core/json_stream_tokenizer_core.sv
// Top level of the JSON stream tokenizer: decode control plus a row of
// stack cells. Depends on jst_pkg, jst_stream_if and jst_cell.
//
// Usage: the input channel carries one text byte or an end-of-input mark per
// word; the result channel carries event words (kind, char, level, error
// code, last flag). Each input word causes zero, one or two result words.
// One input word is accepted per cycle when the result side keeps up and the
// spill slot is empty; a word with two results parks the second in the spill
// slot, which blocks input until it has moved to the output register. The first
// result of a word is registered in the output register.
// The top of the nesting stack always sits in cell 0 of the cell row, so a
// push or pop is a shift of the whole row.
// Reset clears depth and leaf state; the stack cells need no clearing since
// only entries written after a push are read. When the receiver stalls, the
// output register holds its result and input is blocked while that register
// is full and not taken, or while the spill slot holds a word.
`default_nettype none
module json_stream_tokenizer_core #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  jst_stream_if.sink   in_s,
  jst_stream_if.source out_s
);
  import jst_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  // Cell row: cell 0 is the top of the stack.
  stk_ctl_t ctl;
  cstate_t  cells [MAX_DEPTH];

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    cstate_t above, below;
    if (g == 0) begin : g_top
      assign above = ctl.data;
    end else if (g == 1) begin : g_second
      assign above = ctl.old_top;
    end else begin : g_mid
      assign above = cells[g-1];
    end
    if (g == MAX_DEPTH - 1) begin : g_last
      assign below = cells[g];
    end else begin : g_inner
      assign below = cells[g+1];
    end
    jst_cell u_cell (
      .clk(clk), .ctl(ctl), .from_above(above), .from_below(below),
      .is_top(g == 0), .entry(cells[g])
    );
  end

  // Leaf and depth state.
  logic [DW-1:0] depth_r, depth_nxt;
  leaf_t         leaf_r, leaf_nxt;
  logic          esc_r, esc_nxt;
  logic [1:0]    nflg_r, nflg_nxt;
  logic [2:0]    lidx_r, lidx_nxt;
  logic          nnz_r, nnz_nxt;

  // Output register plus a spill for the second result.
  res_t out_r, spill_r;
  logic out_v_r, spill_v_r;

  logic [7:0] c;
  logic       eoi;
  assign c   = in_s.data.in_char;
  assign eoi = in_s.data.end_of_input;

  res_t r0, r1;
  logic v0, v1;
  logic fire;
  logic out_free;

  // Input is accepted only when both holding slots can take two results.
  assign out_free   = !spill_v_r && (!out_v_r || out_s.ready);
  assign in_s.ready = out_free;
  assign fire       = in_s.valid && in_s.ready;

  // Next state and up to two results for the current word.
  always_comb begin
    logic       ws, isnum, dec, err, cont, endn;
    logic [2:0] ecode;
    cstate_t    s;
    logic [7:0] dc;
    logic [DW-1:0] d0;
    event_t     k0;
    logic [7:0] ch0;

    depth_nxt = depth_r; leaf_nxt = leaf_r; esc_nxt = esc_r;
    nflg_nxt = nflg_r; lidx_nxt = lidx_r; nnz_nxt = nnz_r;
    ctl.op = OP_HOLD; ctl.data = S_OBJ_BEGIN; ctl.old_top = cells[0];
    v0 = 1'b0; v1 = 1'b0; r0 = '0; r1 = '0;
    err = 1'b0; ecode = ER_NONE; cont = 1'b0; endn = 1'b0;
    k0 = EV_OBJ_OPEN; ch0 = 8'h00; dc = c;
    ws = (c == " ") || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
    isnum = (c >= "0" && c <= "9") || (c == ".");
    s = cells[0];
    d0 = depth_r;

    case (leaf_r)
      L_NAME, L_STR: begin
        if (depth_r == '0) begin
          err = 1'b1; ecode = ER_UNEXP;
        end else if (eoi) begin
          err = 1'b1; ecode = ER_END;
        end else if (esc_r) begin
          case (c)
            "n": dc = 8'h0a;
            "t": dc = 8'h09;
            "r": dc = 8'h0d;
            "b": dc = 8'h08;
            "f": dc = 8'h0c;
            default: dc = c;
          endcase
          esc_nxt = 1'b0;
          v0 = 1'b1; ch0 = dc;
          k0 = (leaf_r == L_NAME) ? EV_NAME_CHAR : EV_STR_CHAR;
          if (leaf_r == L_NAME) nnz_nxt = 1'b1;
        end else if (c == "\"") begin
          leaf_nxt = L_NONE;
          if (leaf_r == L_NAME) begin
            if (!nnz_r) begin
              err = 1'b1; ecode = ER_EMPTY;
            end else begin
              nnz_nxt = 1'b0;
              ctl.op = OP_WRTOP; ctl.data = S_OBJ_COLON;
              v0 = 1'b1; k0 = EV_NAME_END;
            end
          end else begin
            v0 = 1'b1; k0 = EV_STR_END;
          end
        end else if (c == "\\") begin
          esc_nxt = 1'b1;
        end else begin
          v0 = 1'b1; ch0 = c;
          k0 = (leaf_r == L_NAME) ? EV_NAME_CHAR : EV_STR_CHAR;
          if (leaf_r == L_NAME) nnz_nxt = 1'b1;
        end
      end
      L_NUM: begin
        if (!eoi && isnum) begin
          if (c == ".") begin
            if (nflg_r[1]) begin
              err = 1'b1; ecode = ER_POINT;
            end else begin
              nflg_nxt = 2'b10;
            end
          end else begin
            nflg_nxt = nflg_r | 2'b01;
          end
          if (!err) begin
            v0 = 1'b1; k0 = EV_NUM_CHAR; ch0 = c;
          end
        end else if (!nflg_r[0]) begin
          err = 1'b1; ecode = ER_NO_DIGITS;
        end else begin
          leaf_nxt = L_NONE; nflg_nxt = 2'b00;
          v0 = 1'b1; k0 = EV_NUM_END;
          endn = 1'b1; cont = 1'b1;
        end
      end
      L_TRUE, L_FALSE, L_NULL: begin
        if (eoi || lit_char(leaf_r, lidx_r) == 8'h00 ||
            c != lit_char(leaf_r, lidx_r)) begin
          err = 1'b1; ecode = ER_UNEXP;
        end else if (lit_char(leaf_r, lidx_r + 3'd1) == 8'h00) begin
          leaf_nxt = L_NONE; lidx_nxt = 3'd0;
          v0 = 1'b1;
          k0 = (leaf_r == L_TRUE) ? EV_TRUE :
               (leaf_r == L_FALSE) ? EV_FALSE : EV_NULL;
        end else begin
          lidx_nxt = lidx_r + 3'd1;
        end
      end
      default: cont = 1'b1;
    endcase

    // Container handling, possibly after a number end.
    if (cont) begin
      logic       vs, pv, popv;
      event_t     kc;
      logic [7:0] cc;
      vs = 1'b0; pv = 1'b0; popv = 1'b0; kc = EV_OBJ_OPEN; cc = 8'h00;
      if (depth_r == '0) begin
        if (!(eoi || ws)) begin
          if (c == "{") begin
            pv = 1'b1; ctl.data = S_OBJ_BEGIN; kc = EV_OBJ_OPEN;
          end else begin
            err = 1'b1; ecode = ER_UNEXP;
          end
        end
      end else if (s == S_ARR_BEGIN || s == S_ARR_END) begin
        if (eoi) begin
          err = 1'b1; ecode = ER_END;
        end else if (c == "]") begin
          popv = 1'b1; kc = EV_ARR_CLOSE;
        end else if (s == S_ARR_BEGIN) begin
          if (ws) begin
            ctl.op = OP_WRTOP; ctl.data = S_ARR_VALUE;
          end else begin
            vs = 1'b1;
          end
        end else if (c == ",") begin
          ctl.op = OP_WRTOP; ctl.data = S_ARR_BEGIN;
        end else if (!ws) begin
          err = 1'b1; ecode = ER_UNEXP;
        end
      end else if (ws && !eoi) begin
        // Whitespace between tokens is dropped.
      end else if (eoi) begin
        err = 1'b1; ecode = ER_END;
      end else begin
        case (s)
          S_OBJ_BEGIN: begin
            if (c == "\"") begin
              leaf_nxt = L_NAME; esc_nxt = 1'b0; nnz_nxt = 1'b0;
            end else if (c == "}") begin
              popv = 1'b1; kc = EV_OBJ_CLOSE;
            end else begin
              err = 1'b1; ecode = ER_UNEXP;
            end
          end
          S_OBJ_COLON: begin
            if (c == ":") begin
              ctl.op = OP_WRTOP; ctl.data = S_OBJ_VALUE;
            end else begin
              err = 1'b1; ecode = ER_UNEXP;
            end
          end
          S_OBJ_END: begin
            if (c == ",") begin
              ctl.op = OP_WRTOP; ctl.data = S_OBJ_BEGIN;
            end else if (c == "}") begin
              popv = 1'b1; kc = EV_OBJ_CLOSE;
            end else begin
              err = 1'b1; ecode = ER_UNEXP;
            end
          end
          default: vs = 1'b1;
        endcase
      end

      // Start of a value: mark the container done, then open the leaf.
      if (vs) begin
        ctl.op = OP_WRTOP;
        ctl.data = (s >= S_ARR_BEGIN) ? S_ARR_END : S_OBJ_END;
        ctl.old_top = ctl.data;
        if (isnum) begin
          leaf_nxt = L_NUM;
          vs = 1'b1;
          if (c == ".") nflg_nxt = 2'b10;
          else nflg_nxt = 2'b01;
          kc = EV_NUM_CHAR; cc = c;
        end else if (c == "-") begin
          leaf_nxt = L_NUM; nflg_nxt = 2'b00;
          kc = EV_NUM_CHAR; cc = c;
        end else if (c == "\"") begin
          leaf_nxt = L_STR; esc_nxt = 1'b0; vs = 1'b0;
        end else if (c == "{" || c == "[") begin
          vs = 1'b0; pv = 1'b1;
          kc = (c == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN;
        end else if (c == "t" || c == "f" || c == "n") begin
          leaf_nxt = (c == "t") ? L_TRUE : (c == "f") ? L_FALSE : L_NULL;
          lidx_nxt = 3'd1; vs = 1'b0;
        end else begin
          vs = 1'b0; err = 1'b1; ecode = ER_UNEXP;
        end
      end

      // A push after a value start writes the done state into the old top,
      // then shifts; the new top gets the fresh container state.
      if (pv) begin
        if (depth_r >= DW'(MAX_DEPTH)) begin
          err = 1'b1; ecode = ER_DEEP;
        end else begin
          ctl.op = OP_PUSH;
          ctl.data = (c == "[") ? S_ARR_BEGIN : S_OBJ_BEGIN;
          depth_nxt = depth_r + DW'(1);
          vs = 1'b1;
        end
      end
      if (popv) begin
        ctl.op = OP_POP;
        depth_nxt = depth_r - DW'(1);
        vs = 1'b1;
      end

      if (vs && !err) begin
        if (endn) begin
          v1 = 1'b1;
          r1.event_kind = kc; r1.char_out = cc;
          r1.nest_level = 6'(depth_nxt); r1.error_code = ER_NONE;
        end else begin
          v0 = 1'b1; k0 = kc; ch0 = cc; d0 = depth_nxt;
        end
      end
    end

    if (!endn) d0 = depth_nxt;

    // Any error clears everything and reports a single error result.
    if (err) begin
      depth_nxt = '0; leaf_nxt = L_NONE; esc_nxt = 1'b0;
      nflg_nxt = 2'b00; lidx_nxt = 3'd0; nnz_nxt = 1'b0;
      ctl.op = OP_HOLD;
      if (endn) begin
        v1 = 1'b1;
        r1 = '0; r1.event_kind = EV_ERROR; r1.error_code = ecode;
      end else begin
        v0 = 1'b1; k0 = EV_ERROR; ch0 = 8'h00; d0 = '0;
      end
    end

    r0.event_kind = k0;
    r0.char_out   = ch0;
    r0.nest_level = 6'(d0);
    r0.error_code = (k0 == EV_ERROR) ? ecode : ER_NONE;
    r0.last_event = !v1;
    r1.last_event = 1'b1;
    if (!fire) begin
      ctl.op = OP_HOLD;
      v0 = 1'b0; v1 = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0; leaf_r <= L_NONE; esc_r <= 1'b0;
      nflg_r <= 2'b00; lidx_r <= 3'd0; nnz_r <= 1'b0;
    end else if (fire) begin
      depth_r <= depth_nxt; leaf_r <= leaf_nxt; esc_r <= esc_nxt;
      nflg_r <= nflg_nxt; lidx_r <= lidx_nxt; nnz_r <= nnz_nxt;
    end
  end

  // Output register and spill slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0; spill_v_r <= 1'b0;
    end else begin
      if (out_s.ready || !out_v_r) begin
        if (spill_v_r) begin
          out_r <= spill_r; out_v_r <= 1'b1; spill_v_r <= 1'b0;
        end else begin
          out_v_r <= v0;
          out_r   <= r0;
          if (v1) begin
            spill_r <= r1; spill_v_r <= 1'b1;
          end
        end
      end
    end
  end

  assign out_s.valid = out_v_r;
  assign out_s.data  = out_r;
endmodule
`default_nettype wire
